>>> design/hsv2rgb_pkg.sv
// Shared types and fixed-point constants for the HSV to RGB pixel converter.
package hsv2rgb_pkg;

	localparam int HUE_FRAC_BITS = 6;

	localparam int SPAN     = 60 << HUE_FRAC_BITS;
	localparam int SPAN_W   = $clog2(SPAN + 1);
	localparam int FULL     = 255 * SPAN;
	localparam int N_W      = $clog2(FULL + 1);
	localparam int HALF     = FULL / 2;
	localparam int X_W      = $clog2(255 * FULL + HALF + 1);
	localparam int DEN_SHIFT = HUE_FRAC_BITS + 2;
	localparam int DEN_ODD  = FULL >> DEN_SHIFT;
	localparam int Y_W      = X_W - DEN_SHIFT;

	localparam int RECIP_SHIFT = 32;
	localparam longint RECIP   = (longint'(1) << RECIP_SHIFT) / DEN_ODD;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int P_W         = Y_W + RECIP_W;

	localparam int U_W = $clog2(7 * 60);

	typedef enum logic [1:0] {
		MODE_COLOR,
		MODE_GREY,
		MODE_BLACK,
		MODE_HUE_ERR
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [2:0] sector;
		logic [7:0] v;
	} pix_ctl_t;

	typedef struct packed {
		logic ld_s3;
		logic ld_s4;
	} lane_ld_t;

endpackage

>>> design/hsv2rgb_sector_decode.sv
// First pipeline stage: hue sector, remainder within the sector, and pixel class.
module hsv2rgb_sector_decode (
	input  logic                           clk,
	input  logic                           ld,
	input  logic signed [15:0]             hue,
	input  logic [7:0]                     saturation,
	input  logic [7:0]                     value,
	output hsv2rgb_pkg::pix_ctl_t          ctl_s1,
	output logic [7:0]                     sat_s1,
	output logic [hsv2rgb_pkg::SPAN_W-1:0] rem_s1
);
	import hsv2rgb_pkg::*;

	localparam logic [15:0] FRAC_MASK = 16'((1 << HUE_FRAC_BITS) - 1);

	logic signed [15:0] hs;
	logic               in_range;
	logic [U_W-1:0]     u;
	logic [2:0]         k;
	logic [5:0]         ru;
	logic [15:0]        hue_bits;
	logic [SPAN_W-1:0]  rem;
	pix_ctl_t           ctl;

	assign hue_bits = hue;
	assign hs       = hue >>> HUE_FRAC_BITS;
	assign in_range = (hs >= -16'sd60) && (hs < 16'sd420);
	assign u        = U_W'(hs + 16'sd60);

	always_comb begin
		k = 3'd0;
		for (int j = 1; j <= 7; j++) begin
			if (u >= U_W'(60 * j)) begin
				k = k + 3'd1;
			end
		end
	end

	assign ru  = 6'(u - U_W'(k) * U_W'(60));
	assign rem = (SPAN_W'(ru) << HUE_FRAC_BITS) | SPAN_W'(hue_bits & FRAC_MASK);

	always_comb begin
		ctl.v = value;
		case (k)
			3'd0:    ctl.sector = 3'd5;
			3'd7:    ctl.sector = 3'd0;
			default: ctl.sector = k - 3'd1;
		endcase
		if (value == 8'd0) begin
			ctl.mode = MODE_BLACK;
		end else if (saturation == 8'd0) begin
			ctl.mode = MODE_GREY;
		end else if (!in_range) begin
			ctl.mode = MODE_HUE_ERR;
		end else begin
			ctl.mode = MODE_COLOR;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ctl_s1 <= ctl;
			sat_s1 <= saturation;
			rem_s1 <= rem;
		end
	end

endmodule

>>> design/hsv2rgb_level_scale.sv
// One level lane: scale by value, then round-to-nearest divide by the fixed denominator.
module hsv2rgb_level_scale (
	input  logic                        clk,
	input  hsv2rgb_pkg::lane_ld_t       ld,
	input  logic [hsv2rgb_pkg::N_W-1:0] n,
	input  logic [7:0]                  v,
	output logic [7:0]                  level
);
	import hsv2rgb_pkg::*;

	logic [X_W-1:0] x;
	logic [Y_W-1:0] y_s3;
	logic [P_W-1:0] prod;
	logic [7:0]     est_s4;
	logic [Y_W-1:0] y_s4;
	logic [Y_W-1:0] back;
	logic [Y_W-1:0] rmd;

	assign x = X_W'(v) * X_W'(n) + X_W'(HALF);

	always_ff @(posedge clk) begin
		if (ld.ld_s3) begin
			y_s3 <= Y_W'(x >> DEN_SHIFT);
		end
	end

	assign prod = P_W'(y_s3) * P_W'(RECIP);

	always_ff @(posedge clk) begin
		if (ld.ld_s4) begin
			est_s4 <= 8'(prod >> RECIP_SHIFT);
			y_s4   <= y_s3;
		end
	end

	assign back  = Y_W'(est_s4) * Y_W'(DEN_ODD);
	assign rmd   = y_s4 - back;
	assign level = est_s4 + 8'(rmd >= Y_W'(DEN_ODD));

endmodule

>>> design/hsv_to_rgb_pixel_convert.sv
// Top level of the HSV to RGB pixel converter: five-stage pipeline with valid/stall handshake.
//
// Converts one pixel per clock while out_stall is low. An accepted input beat passes
// through the stages to its output beat in order: sector decode, level numerators, value
// scaling, reciprocal estimate, then correction and channel routing into the output
// register. Each stage holds one beat; a stall on the output freezes only the full stages
// ahead of the first empty one, so bubbles are squeezed out and nothing is dropped.
// Hue is in 1/64 degree; outside -60 to just under 420 degrees hue_error is set and
// the channels are zero, unless value or saturation is zero (black or grey).
module hsv_to_rgb_pixel_convert (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] hue,
	input  logic [7:0]         saturation,
	input  logic [7:0]         value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               hue_error
);
	import hsv2rgb_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;

	pix_ctl_t          ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [7:0]        sat_s1;
	logic [SPAN_W-1:0] rem_s1;
	logic [SPAN_W-1:0] drem;
	logic [N_W-1:0]    sr, st;
	logic [N_W-1:0]    np, nq, nt;
	logic [N_W-1:0]    np_s2, nq_s2, nt_s2;
	lane_ld_t          lane_ld;
	logic [7:0]        p_lvl, q_lvl, t_lvl;
	logic [7:0]        r_d, g_d, b_d;
	logic              err_d;
	logic [7:0]        red_s5, green_s5, blue_s5;
	logic              hue_error_s5;

	assign ready_s5 = !valid_s5 || !out_stall;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
			if (ready_s5) valid_s5 <= valid_s4;
		end
	end

	hsv2rgb_sector_decode u_decode (
		.clk        (clk),
		.ld         (ready_s1 && in_valid),
		.hue        (hue),
		.saturation (saturation),
		.value      (value),
		.ctl_s1     (ctl_s1),
		.sat_s1     (sat_s1),
		.rem_s1     (rem_s1)
	);

	assign drem = SPAN_W'(SPAN) - rem_s1;
	assign sr   = N_W'(sat_s1) * N_W'(rem_s1);
	assign st   = N_W'(sat_s1) * N_W'(drem);
	assign np   = N_W'(8'd255 - sat_s1) * N_W'(SPAN);
	assign nq   = N_W'(FULL) - sr;
	assign nt   = N_W'(FULL) - st;

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			ctl_s2 <= ctl_s1;
			np_s2  <= np;
			nq_s2  <= nq;
			nt_s2  <= nt;
		end
		if (ready_s3 && valid_s2) begin
			ctl_s3 <= ctl_s2;
		end
		if (ready_s4 && valid_s3) begin
			ctl_s4 <= ctl_s3;
		end
	end

	assign lane_ld.ld_s3 = ready_s3 && valid_s2;
	assign lane_ld.ld_s4 = ready_s4 && valid_s3;

	hsv2rgb_level_scale u_lane_p (
		.clk   (clk),
		.ld    (lane_ld),
		.n     (np_s2),
		.v     (ctl_s2.v),
		.level (p_lvl)
	);

	hsv2rgb_level_scale u_lane_q (
		.clk   (clk),
		.ld    (lane_ld),
		.n     (nq_s2),
		.v     (ctl_s2.v),
		.level (q_lvl)
	);

	hsv2rgb_level_scale u_lane_t (
		.clk   (clk),
		.ld    (lane_ld),
		.n     (nt_s2),
		.v     (ctl_s2.v),
		.level (t_lvl)
	);

	always_comb begin
		r_d   = 8'd0;
		g_d   = 8'd0;
		b_d   = 8'd0;
		err_d = 1'b0;
		case (ctl_s4.mode)
			MODE_BLACK: begin
				r_d = 8'd0;
			end
			MODE_GREY: begin
				r_d = ctl_s4.v;
				g_d = ctl_s4.v;
				b_d = ctl_s4.v;
			end
			MODE_HUE_ERR: begin
				err_d = 1'b1;
			end
			MODE_COLOR: begin
				case (ctl_s4.sector)
					3'd0: begin
						r_d = ctl_s4.v; g_d = t_lvl;    b_d = p_lvl;
					end
					3'd1: begin
						r_d = q_lvl;    g_d = ctl_s4.v; b_d = p_lvl;
					end
					3'd2: begin
						r_d = p_lvl;    g_d = ctl_s4.v; b_d = t_lvl;
					end
					3'd3: begin
						r_d = p_lvl;    g_d = q_lvl;    b_d = ctl_s4.v;
					end
					3'd4: begin
						r_d = t_lvl;    g_d = p_lvl;    b_d = ctl_s4.v;
					end
					3'd5: begin
						r_d = ctl_s4.v; g_d = p_lvl;    b_d = q_lvl;
					end
					default: begin
						r_d = 8'd0;
					end
				endcase
			end
			default: begin
				r_d = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ready_s5 && valid_s4) begin
			ctl_s5       <= ctl_s4;
			red_s5       <= r_d;
			green_s5     <= g_d;
			blue_s5      <= b_d;
			hue_error_s5 <= err_d;
		end
	end

	assign out_valid = valid_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;
	assign hue_error = hue_error_s5;

	a_err_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hue_error |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("hue error beat carries nonzero color");

	a_grey_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ctl_s5.mode == MODE_GREY |-> red == green && green == blue)
		else $error("grey beat has unequal channels");

	a_color_has_v: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ctl_s5.mode == MODE_COLOR |->
		red == ctl_s5.v || green == ctl_s5.v || blue == ctl_s5.v)
		else $error("color beat lost its value channel");

	a_no_stall_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s5)
		else $error("input stalled with an empty stage");

endmodule

>>> tb/tb_hsv_to_rgb_pixel_convert.sv
// Self-checking testbench for the HSV to RGB pixel converter with random handshake idling.
module tb_hsv_to_rgb_pixel_convert;
	timeunit 1ns;
	timeprecision 1ps;

	import hsv2rgb_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int MAX_PRINTED = 100;

	typedef struct {
		logic signed [15:0] hue;
		logic [7:0]         sat;
		logic [7:0]         val;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic               err;
	} pixel_check_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] hue = '0;
	logic [7:0]         saturation = '0;
	logic [7:0]         value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               hue_error;

	pixel_check_t pending_rgb[$];
	int  mismatches = 0;
	int  pixels_sent = 0;
	int  pixels_checked = 0;
	int  errors_seen = 0;
	int  flat_seen = 0;
	int  idle_cycles = 0;
	bit  tx_idle = 1'b0;
	bit  rx_idle = 1'b0;
	bit  rx_hold_req = 1'b0;
	int  rx_hold_left = 0;
	int  rx_stall_left = 0;

	hsv_to_rgb_pixel_convert DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.hue(hue),
		.saturation(saturation),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.hue_error(hue_error)
	);

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic longint scale_level(input logic [7:0] v, input longint num);
		longint span;
		longint den;
		span = longint'(60) << HUE_FRAC_BITS;
		den = 255 * span;
		return (longint'(v) * num + den / 2) / den;
	endfunction

	function automatic pixel_check_t predict_rgb(input logic signed [15:0] h,
			input logic [7:0] s, input logic [7:0] v);
		pixel_check_t px;
		longint span;
		longint hv;
		longint sec;
		longint rem;
		longint full;
		longint p;
		longint q;
		longint t;
		span = longint'(60) << HUE_FRAC_BITS;
		hv = longint'(h);
		px.hue = h;
		px.sat = s;
		px.val = v;
		px.red = '0;
		px.green = '0;
		px.blue = '0;
		px.err = 1'b0;
		if (v == 0) begin
		end else if (s == 0) begin
			px.red = v;
			px.green = v;
			px.blue = v;
		end else begin
			sec = (hv >= 0) ? hv / span : -((-hv + span - 1) / span);
			rem = hv - sec * span;
			full = 255 * span;
			p = scale_level(v, (255 - longint'(s)) * span);
			q = scale_level(v, full - longint'(s) * rem);
			t = scale_level(v, full - longint'(s) * (span - rem));
			if (sec == 6) sec = 0;
			if (sec == -1) sec = 5;
			case (sec)
				0: begin px.red = v; px.green = t[7:0]; px.blue = p[7:0]; end
				1: begin px.red = q[7:0]; px.green = v; px.blue = p[7:0]; end
				2: begin px.red = p[7:0]; px.green = v; px.blue = t[7:0]; end
				3: begin px.red = p[7:0]; px.green = q[7:0]; px.blue = v; end
				4: begin px.red = t[7:0]; px.green = p[7:0]; px.blue = v; end
				5: begin px.red = v; px.green = p[7:0]; px.blue = q[7:0]; end
				default: px.err = 1'b1;
			endcase
		end
		return px;
	endfunction

	task automatic report_mismatch(input string field, input pixel_check_t want, input int got,
			input int exp_val);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("mismatch %s: hue=%0d sat=%0d val=%0d got %0d want %0d at %0t",
				field, want.hue, want.sat, want.val, got, exp_val, $realtime);
	endtask

	task automatic send_pixel(input logic signed [15:0] h, input logic [7:0] s,
			input logic [7:0] v);
		int gap;
		gap = tx_idle ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			hue <= 16'($urandom);
			saturation <= 8'($urandom);
			value <= 8'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		hue <= h;
		saturation <= s;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_rgb.push_back(predict_rgb(h, s, v));
		pixels_sent++;
	endtask

	task automatic rand_pixel(output logic signed [15:0] h, output logic [7:0] s,
			output logic [7:0] v);
		int span;
		int roll;
		span = 60 << HUE_FRAC_BITS;
		roll = $urandom_range(0, 9);
		if (roll < 7)
			h = 16'($urandom_range(0, 7 * span - 1) - span);
		else if (roll == 7)
			h = 16'(($urandom_range(0, 8) - 1) * span + $urandom_range(0, 3) - 2);
		else
			h = 16'($urandom);
		roll = $urandom_range(0, 19);
		s = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : (roll == 2) ? 8'd1 : 8'($urandom);
		roll = $urandom_range(0, 19);
		v = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : (roll == 2) ? 8'd1 : 8'($urandom);
	endtask

	task automatic test_color_corners();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_pixel(0, 255, 255);
		send_pixel(3840, 255, 255);
		send_pixel(7680, 200, 180);
		send_pixel(11520, 128, 77);
		send_pixel(15360, 255, 1);
		send_pixel(19200, 1, 255);
		send_pixel(23040, 255, 255);
		send_pixel(26879, 255, 255);
		send_pixel(26880, 255, 255);
		send_pixel(-1, 255, 255);
		send_pixel(-3840, 100, 200);
		send_pixel(-3841, 100, 200);
		send_pixel(-32768, 255, 255);
		send_pixel(32767, 255, 255);
		send_pixel(32767, 0, 128);
		send_pixel(-32768, 0, 255);
		send_pixel(32767, 255, 0);
		send_pixel(1920, 255, 255);
		send_pixel(3839, 255, 255);
		send_pixel(5000, 0, 0);
		send_pixel(12345, 254, 254);
		send_pixel(-2000, 37, 211);
		send_pixel(20000, 128, 128);
	endtask

	task automatic test_full_rate();
		logic signed [15:0] h;
		logic [7:0] s;
		logic [7:0] v;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (200) begin
			rand_pixel(h, s, v);
			send_pixel(h, s, v);
		end
	endtask

	task automatic test_output_backpressure();
		logic signed [15:0] h;
		logic [7:0] s;
		logic [7:0] v;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_hold_req = 1'b1;
		repeat (40) begin
			rand_pixel(h, s, v);
			send_pixel(h, s, v);
		end
	endtask

	task automatic test_random_pixels();
		logic signed [15:0] h;
		logic [7:0] s;
		logic [7:0] v;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (1740) begin
			rand_pixel(h, s, v);
			send_pixel(h, s, v);
		end
	endtask

	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_req = 1'b0;
			rx_hold_left = HOLD_OFF_CYCLES;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_stall <= 1'b1;
		end else if (!rx_idle) begin
			out_stall <= 1'b0;
		end else if (rx_stall_left > 0) begin
			rx_stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			rx_stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
		end
	end

	always @(posedge clk) begin : check_rgb
		pixel_check_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_rgb.size() == 0) begin
					want = predict_rgb(0, 0, 0);
					report_mismatch("unexpected beat", want, int'(red), 0);
				end else begin
					want = pending_rgb.pop_front();
					pixels_checked++;
					if (want.err) errors_seen++;
					if (want.sat == 0 || want.val == 0) flat_seen++;
					if (red !== want.red)
						report_mismatch("red", want, int'(red), int'(want.red));
					if (green !== want.green)
						report_mismatch("green", want, int'(green), int'(want.green));
					if (blue !== want.blue)
						report_mismatch("blue", want, int'(blue), int'(want.blue));
					if (hue_error !== want.err)
						report_mismatch("hue_error", want, int'(hue_error), int'(want.err));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_color_corners();
		test_full_rate();
		test_output_backpressure();
		test_random_pixels();
		@(negedge clk);
		in_valid <= 1'b0;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		while (pending_rgb.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Converted %0d pixels: %0d with hue out of range, %0d black or grey.",
			pixels_checked, errors_seen, flat_seen);
		$display("Traffic ran at full rate, with random gaps on both sides and a %0d-cycle hold-off.",
			HOLD_OFF_CYCLES);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
design/hsv2rgb_pkg.sv
design/hsv2rgb_sector_decode.sv
design/hsv2rgb_level_scale.sv
design/hsv_to_rgb_pixel_convert.sv
tb/tb_hsv_to_rgb_pixel_convert.sv
